// File: src/brtk_pkg.sv
`default_nettype none
package brtk_pkg;

    localparam int DistW  = 48;
    localparam int RootW  = 24;
    localparam int CountW = 11;
    localparam int KeepW  = 8;
    localparam int TileW  = 11;

    // config register indexes
    localparam logic REG_KEEP_COUNT = 1'b0;
    localparam logic REG_TILE_SIZE  = 1'b1;

    typedef struct packed {
        logic              node_valid;
        logic [DistW-1:0]  refine_distance;
        logic [DistW-1:0]  query_norm;
        logic [RootW-1:0]  error_bound;
        logic [DistW-1:0]  exact_distance;
        logic              last_of_query;
    } in_t;

    typedef struct packed {
        logic              pruned;
        logic              violation;
        logic [DistW-1:0]  violation_margin;
        logic [DistW-1:0]  bound_dist;
        logic [DistW-1:0]  approx_dist;
        logic [DistW-1:0]  threshold_value;
        logic              threshold_finite;
        logic [CountW-1:0] pruned_so_far;
        logic [CountW-1:0] first_pruned_rank;
        logic              query_done;
    } out_t;

    // classified candidate passed from front to back
    typedef struct packed {
        logic             node_valid;
        logic             last;
        logic [DistW-1:0] approx;
        logic [DistW-1:0] lower;
        logic [DistW-1:0] exact;
    } qent_t;

endpackage
`default_nettype wire

// File: src/bound_pruned_topk_rerank.sv
`default_nettype none
// Lower-bound pruned top-k re-ranker.
// Input channel in_valid/in_ready/in_data carries one candidate per
// transaction, in rank order within a query. Output channel
// out_valid/out_ready/out_data returns exactly one result per candidate,
// in order. keep_count and tile_size are set through the APB port
// (0x0 and 0x4); the user must write them only while the block is idle,
// which the block does not enforce. The front takes a candidate, forms
// the approximate distance and its integer root one bit per cycle, then
// squares the root less the error bound (floored at zero), and takes no
// new candidate until that one is pushed. A two-entry queue feeds the
// back, which decides and inserts a candidate as it takes it and
// refreshes the threshold in the next cycle, taking no candidate then.
// A tile size write starts a tile phase recompute of one cycle per rank
// counter bit, during which the back takes no candidate.
// Reset clears all control state; the list needs no clearing pass.
// If the receiver stalls, the result holds in the output register, the
// queue fills, and then the front stops taking candidates.
module bound_pruned_topk_rerank #(
    parameter int MAX_KEEP  = 128,
    parameter int MAX_RANKS = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire brtk_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output brtk_pkg::out_t      out_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import brtk_pkg::*;

    logic [KeepW-1:0] keep_reg;
    logic [TileW-1:0] tile_reg;
    logic             wr_en, tile_wr;
    logic             push, full, pop, empty;
    qent_t            push_data, head;

    // config registers
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign tile_wr = wr_en && (paddr[2] == REG_TILE_SIZE);
    assign prdata  = (paddr[2] == REG_TILE_SIZE) ? 32'(tile_reg) : 32'(keep_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= KeepW'(10);
            tile_reg <= TileW'(16);
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_KEEP_COUNT)
                keep_reg <= pwdata[KeepW-1:0];
            else
                tile_reg <= pwdata[TileW-1:0];
        end
    end

    brtk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    brtk_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    brtk_back #(
        .MAX_KEEP  (MAX_KEEP),
        .MAX_RANKS (MAX_RANKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .keep_count (keep_reg),
        .tile_size  (tile_reg),
        .tile_wr    (tile_wr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire

// File: src/brtk_front.sv
`default_nettype none
module brtk_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire brtk_pkg::in_t in_data,
    output logic               push,
    output brtk_pkg::qent_t    push_data,
    input  wire logic          full
);
    import brtk_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQRT = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [4:0]       cnt_reg;
    logic [DistW-1:0] approx_reg, sh_reg, exact_reg, lower_reg;
    logic [RootW-1:0] eb_reg, root_reg;
    logic [25:0]      rem_reg;
    logic             nv_reg, last_reg;
    logic [27:0]      trial_rem;
    logic [25:0]      trial;
    logic [RootW-1:0] diff;
    logic [DistW-1:0] approx_in;

    assign in_ready = (st_reg == F_IDLE);

    // refine distance minus norm, floored at zero; zero for an invalid node
    always_comb
    begin
        if (!in_data.node_valid)
            approx_in = '0;
        else if (in_data.refine_distance > in_data.query_norm)
            approx_in = in_data.refine_distance - in_data.query_norm;
        else
            approx_in = '0;
    end

    // one root bit per step
    assign trial_rem = {rem_reg, sh_reg[DistW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign diff      = (root_reg > eb_reg) ? root_reg - eb_reg : '0;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            F_IDLE: if (in_valid) st_next = F_SQRT;
            F_SQRT: if (cnt_reg == 5'd0) st_next = F_MUL;
            F_MUL:  st_next = F_PUSH;
            F_PUSH: if (!full) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= F_IDLE;
        else
            st_reg <= st_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (st_reg == F_IDLE && in_valid)
        begin
            approx_reg <= approx_in;
            sh_reg     <= approx_in;
            exact_reg  <= in_data.exact_distance;
            eb_reg     <= in_data.error_bound;
            nv_reg     <= in_data.node_valid;
            last_reg   <= in_data.last_of_query;
            rem_reg    <= '0;
            root_reg   <= '0;
            cnt_reg    <= 5'(RootW - 1);
        end
        else if (st_reg == F_SQRT)
        begin
            if (trial_rem >= 28'(trial))
            begin
                rem_reg  <= 26'(trial_rem - 28'(trial));
                root_reg <= {root_reg[RootW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial_rem[25:0];
                root_reg <= {root_reg[RootW-2:0], 1'b0};
            end
            sh_reg  <= {sh_reg[DistW-3:0], 2'b00};
            cnt_reg <= cnt_reg - 5'd1;
        end
        else if (st_reg == F_MUL)
        begin
            lower_reg <= DistW'(diff) * DistW'(diff);
        end
    end

    assign push                 = (st_reg == F_PUSH) && !full;
    assign push_data.node_valid = nv_reg;
    assign push_data.last       = last_reg;
    assign push_data.approx     = approx_reg;
    assign push_data.lower      = lower_reg;
    assign push_data.exact      = exact_reg;

endmodule
`default_nettype wire

// File: src/brtk_fifo.sv
`default_nettype none
module brtk_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire brtk_pkg::qent_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output brtk_pkg::qent_t      head,
    output logic                 empty
);
    import brtk_pkg::*;

    qent_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

endmodule
`default_nettype wire

// File: src/brtk_back.sv
`default_nettype none
module brtk_back #(
    parameter int MAX_KEEP  = 128,
    parameter int MAX_RANKS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire brtk_pkg::qent_t            head,
    input  wire logic                       empty,
    output logic                            pop,
    input  wire logic [brtk_pkg::KeepW-1:0] keep_count,
    input  wire logic [brtk_pkg::TileW-1:0] tile_size,
    input  wire logic                       tile_wr,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output brtk_pkg::out_t                  out_data
);
    import brtk_pkg::*;

    localparam int KW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int RW = $clog2(MAX_RANKS + 1);
    localparam logic B_DECIDE  = 1'b0;
    localparam logic B_REFRESH = 1'b1;

    logic             st_reg;
    logic [DistW-1:0] list_reg [MAX_KEEP];
    logic [KW-1:0]    fill_reg;
    logic [DistW-1:0] thr_reg;
    logic             thr_set_reg;
    logic [RW-1:0]    rank_reg, pcnt_reg, first_reg;
    logic [TileW-1:0] rem_reg;
    logic             tile_hit_reg, last_reg;
    logic [RW-1:0]    div_sh_reg;
    logic [4:0]       div_cnt_reg;
    out_t             out_reg;
    logic             out_valid_reg;

    logic [KW-1:0]    k_eff, n_held;
    logic [TileW-1:0] tile_eff;
    logic             prune, viol, do_ins;
    logic [MAX_KEEP-1:0] lt, upd;
    logic [DistW-1:0] nval [MAX_KEEP];
    logic [RW-1:0]    rank1, pcnt_next, first_next;
    logic [TileW:0]   rem_inc;
    logic [TileW:0]   div_t;
    logic [IW-1:0]    kidx;
    logic [KW-1:0]    km1;

    // effective k and tile size
    always_comb
    begin
        if (keep_count == '0)
            k_eff = KW'(1);
        else if (32'(keep_count) > 32'(MAX_KEEP))
            k_eff = KW'(MAX_KEEP);
        else
            k_eff = KW'(keep_count);
    end
    assign tile_eff = (tile_size == '0) ? TileW'(1) : tile_size;
    assign n_held   = (fill_reg < k_eff) ? fill_reg : k_eff;
    assign km1      = k_eff - KW'(1);
    assign kidx     = km1[IW-1:0];

    assign pop = (st_reg == B_DECIDE) && !empty && (div_cnt_reg == '0)
                 && (!out_valid_reg || out_ready);

    // prune decision
    assign prune  = head.node_valid && thr_set_reg && (head.lower > thr_reg);
    assign viol   = prune && (head.exact < thr_reg);
    assign do_ins = head.node_valid && !prune;

    // compare-shift cells of the sorted list
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
            lt[i] = (KW'(i) < n_held) && (head.exact < list_reg[i]);
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            upd[i] = do_ins && (KW'(i) < k_eff)
                     && (lt[i] || (KW'(i) == n_held && n_held < k_eff));
            nval[i] = head.exact;
        end
        for (int i = 1; i < MAX_KEEP; i++)
            if (lt[i-1]) nval[i] = list_reg[i-1];
    end

    // counters for this candidate
    assign rank1      = (32'(rank_reg) < MAX_RANKS) ? rank_reg + RW'(1) : RW'(MAX_RANKS);
    assign pcnt_next  = (prune && 32'(pcnt_reg) < MAX_RANKS) ? pcnt_reg + RW'(1) : pcnt_reg;
    assign first_next = (prune && first_reg == '0) ? rank1 : first_reg;
    assign rem_inc    = {1'b0, rem_reg} + (TileW+1)'(1);
    assign div_t      = {rem_reg, div_sh_reg[RW-1]};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
            if (pop && upd[i]) list_reg[i] <= nval[i];
        if (pop)
        begin
            out_reg.pruned            <= prune;
            out_reg.violation         <= viol;
            out_reg.violation_margin  <= viol ? thr_reg - head.exact : '0;
            out_reg.bound_dist        <= head.lower;
            out_reg.approx_dist       <= head.approx;
            out_reg.threshold_value   <= thr_set_reg ? thr_reg : '0;
            out_reg.threshold_finite  <= thr_set_reg;
            out_reg.pruned_so_far     <= CountW'(pcnt_next);
            out_reg.first_pruned_rank <= CountW'(first_next);
            out_reg.query_done        <= head.last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_DECIDE;
            fill_reg      <= '0;
            thr_reg       <= '0;
            thr_set_reg   <= 1'b0;
            rank_reg      <= '0;
            pcnt_reg      <= '0;
            first_reg     <= '0;
            rem_reg       <= '0;
            tile_hit_reg  <= 1'b0;
            last_reg      <= 1'b0;
            div_sh_reg    <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            // tile phase recompute after a tile size write
            if (tile_wr)
            begin
                rem_reg     <= '0;
                div_sh_reg  <= rank_reg;
                div_cnt_reg <= 5'(RW);
            end
            else if (div_cnt_reg != '0)
            begin
                if (div_t >= {1'b0, tile_eff})
                    rem_reg <= TileW'(div_t - {1'b0, tile_eff});
                else
                    rem_reg <= div_t[TileW-1:0];
                div_sh_reg  <= div_sh_reg << 1;
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            unique case (st_reg)
                B_DECIDE:
                begin
                    if (pop)
                    begin
                        out_valid_reg <= 1'b1;
                        pcnt_reg      <= pcnt_next;
                        first_reg     <= first_next;
                        last_reg      <= head.last;
                        if (do_ins && n_held < k_eff) fill_reg <= n_held + KW'(1);
                        if (32'(rank_reg) < MAX_RANKS)
                        begin
                            rank_reg <= rank_reg + RW'(1);
                            if (rem_inc == {1'b0, tile_eff})
                            begin
                                rem_reg      <= '0;
                                tile_hit_reg <= 1'b1;
                            end
                            else
                            begin
                                rem_reg      <= rem_inc[TileW-1:0];
                                tile_hit_reg <= 1'b0;
                            end
                        end
                        else
                            tile_hit_reg <= 1'b0;
                        st_reg <= B_REFRESH;
                    end
                end
                B_REFRESH:
                begin
                    if (last_reg)
                    begin
                        fill_reg    <= '0;
                        thr_reg     <= '0;
                        thr_set_reg <= 1'b0;
                        rank_reg    <= '0;
                        pcnt_reg    <= '0;
                        first_reg   <= '0;
                        rem_reg     <= '0;
                    end
                    else if (tile_hit_reg)
                    begin
                        if (fill_reg >= k_eff)
                        begin
                            thr_reg     <= list_reg[kidx];
                            thr_set_reg <= 1'b1;
                        end
                        else
                        begin
                            thr_reg     <= '0;
                            thr_set_reg <= 1'b0;
                        end
                    end
                    st_reg <= B_DECIDE;
                end
                default: st_reg <= B_DECIDE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_KEEP)
        else $error("list fill beyond capacity");
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rank_reg) <= MAX_RANKS && 32'(pcnt_reg) <= MAX_RANKS)
        else $error("rank or prune count beyond limit");
    a_pop_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (st_reg == B_REFRESH) && out_valid_reg)
        else $error("candidate taken without refresh step");
    a_no_pop_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> !pop)
        else $error("candidate taken during tile phase recompute");
`endif

endmodule
`default_nettype wire
